// File: rtl/ppcs_pkg.sv
// ----------------------------------------------------------------------------
// ppcs_pkg: shared types and constants of the port power-cycle sequencer
// Item structs, per-port record layout, stage and command codes.
// ----------------------------------------------------------------------------
package ppcs_pkg;

    localparam int PORTS_DEF = 8;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESETS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_OFF  = CFG_IDX_W'(1);

    localparam logic [7:0]  MAX_RESETS_RST = 8'd3;
    localparam logic [15:0] POWER_OFF_RST  = 16'd15;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_OFF  = 2'd2;
    localparam logic [1:0] ST_UP   = 2'd3;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_OFF  = 2'd1;
    localparam logic [1:0] CMD_ON   = 2'd2;

    localparam logic [3:0] FL_REBOOT = 4'b0001;
    localparam logic [3:0] FL_MANUAL = 4'b0010;
    localparam logic [3:0] FL_SHUT   = 4'b0100;
    localparam logic [3:0] FL_SUSP   = 4'b1000;

    typedef struct packed {
        logic [2:0]  port;
        logic [31:0] now_seconds;
        logic        auto_request;
        logic        manual_request;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  port_out;
        logic [1:0]  power_command;
        logic [1:0]  stage_out;
        logic        rebooting;
        logic        manual_reboot;
        logic        shut_down;
        logic        suspended;
        logic        clear_error_count;
        logic [7:0]  resets_now;
        logic [15:0] resets_total;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  stage;
        logic        start_pending;
        logic        timer_expired;
        logic [31:0] deadline;
        logic [7:0]  reset_count;
        logic [15:0] total_resets;
        logic [3:0]  status_bits;
    } t_port_rec;

    typedef struct packed {
        logic capture;
        logic read;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
    } t_ctl_sts;

endpackage

// File: rtl/ppcs_ctrl.sv
// ----------------------------------------------------------------------------
// ppcs_ctrl: sequencing controller
// Steps each item through capture, state-table read and commit.
// ----------------------------------------------------------------------------
module ppcs_ctrl
    import ppcs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_WAIT,
        S_READ,
        S_CALC
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_WAIT: begin
                if (i_in_valid && r_ready) n_state = S_READ;
            end
            S_READ: n_state = S_CALC;
            S_CALC: begin
                if (i_sts.out_free) n_state = S_WAIT;
            end
            default: n_state = S_WAIT;
        endcase
        n_ready = (n_state == S_WAIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_in_ready    = r_ready;
    assign o_cmd.capture = i_in_valid && r_ready;
    assign o_cmd.read    = (r_state == S_READ);
    assign o_cmd.commit  = (r_state == S_CALC) && i_sts.out_free;

endmodule

// File: rtl/ppcs_datapath.sv
// ----------------------------------------------------------------------------
// ppcs_datapath: per-port state table and tick update
// Holds the port records, the configuration registers and the result register.
// ----------------------------------------------------------------------------
module ppcs_datapath
    import ppcs_pkg::*;
#(
    parameter int PORTS = PORTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_item,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_ctl_cmd              i_cmd,
    output t_ctl_sts              o_sts,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_item             o_item
);

    localparam int PIDX = $clog2(PORTS);

    t_port_rec   r_mem [PORTS];
    logic [PORTS-1:0] r_vld;
    t_port_rec   r_rd;
    logic        r_rd_vld;
    t_in_item    r_in;
    logic [7:0]  r_max_resets;
    logic [15:0] r_power_off;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [6:0]      port_ext;
    logic [PIDX-1:0] idx;
    logic            in_range;
    t_port_rec       cur, nxt;
    logic [1:0]      cmd;
    logic            clr;
    t_out_item       res;

    assign port_ext = 7'(r_in.port);
    assign idx      = port_ext[PIDX-1:0];
    assign in_range = (32'(r_in.port) < PORTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_resets <= MAX_RESETS_RST;
            r_power_off  <= POWER_OFF_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MAX_RESETS) r_max_resets <= i_cfg_data[7:0];
            else if (i_cfg_index == CFG_POWER_OFF) r_power_off <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_in <= i_item;
    end

    // Record memory: read registered, written once per in-range item at commit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd     <= r_mem[idx];
            r_rd_vld <= r_vld[idx];
        end
        if (i_cmd.commit && in_range) r_mem[idx] <= nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.commit && in_range) begin
            r_vld[idx] <= 1'b1;
        end
    end

    // A port never written since reset reads as its reset record.
    assign cur = r_rd_vld ? r_rd : '0;

    always_comb begin
        nxt = cur;
        cmd = CMD_NONE;
        clr = 1'b0;
        case (cur.stage)
            ST_IDLE: begin
                if (r_in.auto_request) begin
                    if (cur.reset_count >= r_max_resets) begin
                        nxt.status_bits = nxt.status_bits | FL_SHUT | FL_SUSP;
                    end else begin
                        clr              = 1'b1;
                        nxt.reset_count  = cur.reset_count + 8'd1;
                        nxt.total_resets = cur.total_resets + 16'd1;
                        nxt.status_bits  = nxt.status_bits | FL_REBOOT;
                        nxt.stage        = ST_INIT;
                    end
                end
                if (r_in.manual_request) begin
                    nxt.status_bits  = (nxt.status_bits & ~FL_SHUT) | FL_MANUAL;
                    nxt.total_resets = nxt.total_resets + 16'd1;
                    nxt.reset_count  = 8'd0;
                    clr              = 1'b1;
                    nxt.stage        = ST_INIT;
                end
            end
            ST_INIT: begin
                nxt.deadline      = r_in.now_seconds + 32'(r_power_off);
                nxt.start_pending = 1'b1;
                nxt.stage         = ST_OFF;
            end
            ST_OFF: begin
                if (cur.start_pending) begin
                    nxt.start_pending = 1'b0;
                    cmd               = CMD_OFF;
                end
                if (r_in.now_seconds >= cur.deadline) nxt.timer_expired = 1'b1;
                if (nxt.timer_expired) nxt.stage = ST_UP;
            end
            default: begin
                if (cur.timer_expired) begin
                    nxt.timer_expired = 1'b0;
                    cmd               = CMD_ON;
                end
                nxt.stage       = ST_IDLE;
                nxt.status_bits = cur.status_bits & ~(FL_REBOOT | FL_MANUAL | FL_SUSP);
            end
        endcase
    end

    always_comb begin
        res = '0;
        res.port_out = r_in.port;
        if (in_range) begin
            res.power_command     = cmd;
            res.stage_out         = nxt.stage;
            res.rebooting         = |(nxt.status_bits & FL_REBOOT);
            res.manual_reboot     = |(nxt.status_bits & FL_MANUAL);
            res.shut_down         = |(nxt.status_bits & FL_SHUT);
            res.suspended         = |(nxt.status_bits & FL_SUSP);
            res.clear_error_count = clr;
            res.resets_now        = nxt.reset_count;
            res.resets_total      = nxt.total_resets;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_out <= res;
    end

    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_item         = r_out;

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_ready))
        else $error("result register overwritten while full");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed item did not reach the output");

    a_on_is_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.power_command == CMD_ON) |-> (r_out.stage_out == ST_IDLE))
        else $error("power-on command outside the return to idle");

    a_oor_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !in_range) |=> $stable(r_vld))
        else $error("out-of-range port touched the state table");

endmodule

// File: rtl/poe_port_power_cycle_sequencer_unit.sv
// ----------------------------------------------------------------------------
// poe_port_power_cycle_sequencer_unit: per-port power-cycle sequencer
// Runs one restart sequencer per port, one tick item at a time.
// ----------------------------------------------------------------------------
// An accepted item is captured into a register, its port record is read into a
// register, and the result register is loaded at commit. The next item is taken
// only after that commit, which waits while the result register waits to be taken.
// Reset: all port records read as cleared at once through per-port valid bits;
// max_resets returns to 3 and power_off_seconds to 15.
module poe_port_power_cycle_sequencer_unit
    import ppcs_pkg::*;
#(
    parameter int PORTS = PORTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_item              i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_item             o_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    assign o_cfg_ready = 1'b1;

    ppcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ppcs_datapath #(
        .PORTS (PORTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule
